// File: rtl/tpq_pkg.sv
`default_nettype none

package tpq_pkg;

    localparam int DISPLAY_WIDTH  = 800;
    localparam int DISPLAY_HEIGHT = 480;
    localparam int MAX_POINTS     = 5;

    localparam logic [9:0]  DISP_X_MAX = 10'(DISPLAY_WIDTH - 1);
    localparam logic [8:0]  DISP_Y_MAX = 9'(DISPLAY_HEIGHT - 1);
    localparam logic [3:0]  COUNT_MAX  = 4'(MAX_POINTS);
    localparam int          CFG_DATA_W = 20;

    typedef enum logic [1:0] {
        CMD_BUS_ERROR = 2'd0,
        CMD_REPORT    = 2'd1,
        CMD_RECOVERED = 2'd2,
        CMD_RESERVED  = 2'd3
    } command_t;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_PRESSED  = 2'd1,
        EV_MOVED    = 2'd2,
        EV_RELEASED = 2'd3
    } event_kind_t;

    typedef enum logic [2:0] {
        CLS_BUS_ERROR = 3'd0,
        CLS_IDLE      = 3'd1,
        CLS_INVALID   = 3'd2,
        CLS_TOUCH     = 3'd3,
        CLS_RECOVERED = 3'd4
    } sample_class_t;

    typedef enum logic [2:0] {
        REG_RAW_WIDTH       = 3'd0,
        REG_RAW_HEIGHT      = 3'd1,
        REG_CAND_RADIUS_SQ  = 3'd2,
        REG_MOVE_RADIUS_SQ  = 3'd3,
        REG_MOVE_INTERVAL   = 3'd4,
        REG_PRESS_SAMPLES   = 3'd5,
        REG_RELEASE_SAMPLES = 3'd6,
        REG_ERROR_THRESHOLD = 3'd7
    } cfg_index_t;

    typedef struct packed {
        command_t    command;
        logic [7:0]  status_byte;
        logic [11:0] raw_x;
        logic [11:0] raw_y;
        logic [31:0] time_ms;
    } in_word_t;

    typedef struct packed {
        event_kind_t   event_kind;
        logic [9:0]    point_x;
        logic [8:0]    point_y;
        logic [11:0]   point_raw_x;
        logic [11:0]   point_raw_y;
        logic [2:0]    touch_count;
        logic [31:0]   event_time_ms;
        sample_class_t sample_class;
        logic          recover_request;
    } out_word_t;

    typedef struct packed {
        logic [11:0] raw_width;
        logic [11:0] raw_height;
        logic [19:0] cand_radius_sq;
        logic [19:0] move_radius_sq;
        logic [15:0] move_interval_ms;
        logic [3:0]  press_samples;
        logic [3:0]  release_samples;
        logic [7:0]  error_threshold;
    } cfg_t;

    typedef struct packed {
        logic [9:0]  x;
        logic [8:0]  y;
        logic [11:0] rx;
        logic [11:0] ry;
    } point_t;

    typedef struct packed {
        logic   idle;
        logic   in_range;
        point_t point;
    } map_t;

endpackage

`default_nettype wire

// File: rtl/tpq_map.sv
`default_nettype none

module tpq_map
    import tpq_pkg::*;
(
    input  wire in_word_t sample,
    input  wire cfg_t     cfg,
    output map_t          map
);

    logic [3:0]  count;
    logic [11:0] mirror_y;

    always_comb
    begin
        count    = sample.status_byte[3:0];
        mirror_y = cfg.raw_width - 12'd1 - sample.raw_x;

        map.idle     = (count == 4'd0) || (count > COUNT_MAX);
        map.in_range = (sample.raw_x < cfg.raw_width) && (sample.raw_y < cfg.raw_height);

        map.point.rx = sample.raw_x;
        map.point.ry = sample.raw_y;
        map.point.x  = (sample.raw_y < 12'(DISP_X_MAX)) ? sample.raw_y[9:0] : DISP_X_MAX;
        map.point.y  = (mirror_y > 12'(DISP_Y_MAX)) ? DISP_Y_MAX : mirror_y[8:0];
    end

endmodule

`default_nettype wire

// File: rtl/tpq_core.sv
`default_nettype none

module tpq_core
    import tpq_pkg::*;
(
    input  wire            clk,
    input  wire            rst_n,
    input  wire            step,
    input  wire in_word_t  sample,
    input  wire map_t      map,
    input  wire cfg_t      cfg,
    output out_word_t      result
);

    logic        pressed_reg,     pressed_next;
    logic        awaiting_reg,    awaiting_next;
    logic [3:0]  clear_run_reg,   clear_run_next;
    logic [3:0]  cand_run_reg,    cand_run_next;
    logic [3:0]  release_run_reg, release_run_next;
    logic [7:0]  error_run_reg,   error_run_next;
    point_t      cand_reg,        cand_next;
    point_t      stable_reg,      stable_next;
    logic [9:0]  last_x_reg,      last_x_next;
    logic [8:0]  last_y_reg,      last_y_next;
    logic [31:0] last_time_reg,   last_time_next;

    point_t      s;
    point_t      avg;
    point_t      smooth;
    logic [9:0]  da_x, db_x;
    logic [8:0]  da_y, db_y;
    logic [19:0] dist_val;
    logic [3:0]  sat_clear, sat_cand, sat_release;
    logic [31:0] elapsed;

    function automatic logic [3:0] sat_inc(input logic [3:0] v);
        return (v == 4'd15) ? v : v + 4'd1;
    endfunction

    function automatic logic [11:0] smooth12(input logic [11:0] p, input logic [11:0] n);
        logic [13:0] sum;
        sum = {1'b0, p, 1'b0} + 14'(p) + 14'(n) + 14'd2;
        return sum[13:2];
    endfunction

    function automatic logic [11:0] avg12(input logic [11:0] a, input logic [11:0] b);
        logic [12:0] sum;
        sum = 13'(a) + 13'(b);
        return sum[12:1];
    endfunction

    function automatic logic [19:0] dist_sq(input logic [9:0] ax, input logic [8:0] ay,
                                            input logic [9:0] bx, input logic [8:0] by);
        logic [9:0]  dx;
        logic [8:0]  dy;
        logic [19:0] sx;
        logic [19:0] sy;
        dx = (ax > bx) ? ax - bx : bx - ax;
        dy = (ay > by) ? ay - by : by - ay;
        sx = 20'(dx) * 20'(dx);
        sy = 20'(dy) * 20'(dy);
        return sx + sy;
    endfunction

    always_comb
    begin
        s = map.point;

        avg.x  = 10'(avg12(12'(cand_reg.x), 12'(s.x)));
        avg.y  = 9'(avg12(12'(cand_reg.y), 12'(s.y)));
        avg.rx = avg12(cand_reg.rx, s.rx);
        avg.ry = avg12(cand_reg.ry, s.ry);

        smooth.x  = 10'(smooth12(12'(stable_reg.x), 12'(s.x)));
        smooth.y  = 9'(smooth12(12'(stable_reg.y), 12'(s.y)));
        smooth.rx = smooth12(stable_reg.rx, s.rx);
        smooth.ry = smooth12(stable_reg.ry, s.ry);

        // share one distance unit between press qualification and move gating
        da_x = pressed_reg ? smooth.x   : cand_reg.x;
        da_y = pressed_reg ? smooth.y   : cand_reg.y;
        db_x = pressed_reg ? last_x_reg : s.x;
        db_y = pressed_reg ? last_y_reg : s.y;
        dist_val = dist_sq(da_x, da_y, db_x, db_y);

        sat_clear   = sat_inc(clear_run_reg);
        sat_cand    = sat_inc(cand_run_reg);
        sat_release = sat_inc(release_run_reg);
        elapsed     = sample.time_ms - last_time_reg;
    end

    always_comb
    begin
        pressed_next     = pressed_reg;
        awaiting_next    = awaiting_reg;
        clear_run_next   = clear_run_reg;
        cand_run_next    = cand_run_reg;
        release_run_next = release_run_reg;
        error_run_next   = error_run_reg;
        cand_next        = cand_reg;
        stable_next      = stable_reg;
        last_x_next      = last_x_reg;
        last_y_next      = last_y_reg;
        last_time_next   = last_time_reg;

        result              = '0;
        result.sample_class = CLS_INVALID;

        unique case (sample.command)
            CMD_RESERVED:
            begin
                result.sample_class = CLS_INVALID;
            end
            CMD_BUS_ERROR:
            begin
                error_run_next         = (error_run_reg == 8'hFF) ? error_run_reg
                                                                  : error_run_reg + 8'd1;
                result.sample_class    = CLS_BUS_ERROR;
                result.recover_request = (error_run_next >= cfg.error_threshold);
            end
            CMD_RECOVERED:
            begin
                error_run_next      = '0;
                cand_run_next       = '0;
                release_run_next    = '0;
                clear_run_next      = '0;
                pressed_next        = 1'b0;
                awaiting_next       = 1'b1;
                result.sample_class = CLS_RECOVERED;
            end
            CMD_REPORT:
            begin
                error_run_next = '0;
                if (map.idle)
                begin
                    result.sample_class = CLS_IDLE;
                    if (awaiting_reg)
                    begin
                        if (sat_clear >= cfg.release_samples)
                        begin
                            awaiting_next  = 1'b0;
                            clear_run_next = '0;
                        end
                        else
                        begin
                            clear_run_next = sat_clear;
                        end
                    end
                    else
                    begin
                        cand_run_next = '0;
                        if (pressed_reg)
                        begin
                            if (sat_release >= cfg.release_samples)
                            begin
                                pressed_next       = 1'b0;
                                release_run_next   = '0;
                                result.event_kind  = EV_RELEASED;
                                result.point_x     = stable_reg.x;
                                result.point_y     = stable_reg.y;
                                result.point_raw_x = stable_reg.rx;
                                result.point_raw_y = stable_reg.ry;
                                result.event_time_ms = sample.time_ms;
                                last_x_next        = stable_reg.x;
                                last_y_next        = stable_reg.y;
                                last_time_next     = sample.time_ms;
                            end
                            else
                            begin
                                release_run_next = sat_release;
                            end
                        end
                    end
                end
                else if (!map.in_range)
                begin
                    result.sample_class = CLS_INVALID;
                end
                else
                begin
                    result.sample_class = CLS_TOUCH;
                    if (awaiting_reg)
                    begin
                        clear_run_next = '0;
                    end
                    else
                    begin
                        release_run_next = '0;
                        if (!pressed_reg)
                        begin
                            if (cand_run_reg == 4'd0 || dist_val > cfg.cand_radius_sq)
                            begin
                                cand_next     = s;
                                cand_run_next = 4'd1;
                            end
                            else
                            begin
                                cand_next = avg;
                                if (sat_cand < cfg.press_samples)
                                begin
                                    cand_run_next = sat_cand;
                                end
                                else
                                begin
                                    pressed_next         = 1'b1;
                                    cand_run_next        = '0;
                                    stable_next          = avg;
                                    result.event_kind    = EV_PRESSED;
                                    result.point_x       = avg.x;
                                    result.point_y       = avg.y;
                                    result.point_raw_x   = avg.rx;
                                    result.point_raw_y   = avg.ry;
                                    result.touch_count   = sample.status_byte[2:0];
                                    result.event_time_ms = sample.time_ms;
                                    last_x_next          = avg.x;
                                    last_y_next          = avg.y;
                                    last_time_next       = sample.time_ms;
                                end
                            end
                        end
                        else
                        begin
                            stable_next = smooth;
                            if (dist_val >= cfg.move_radius_sq
                                && elapsed >= 32'(cfg.move_interval_ms))
                            begin
                                result.event_kind    = EV_MOVED;
                                result.point_x       = smooth.x;
                                result.point_y       = smooth.y;
                                result.point_raw_x   = smooth.rx;
                                result.point_raw_y   = smooth.ry;
                                result.touch_count   = sample.status_byte[2:0];
                                result.event_time_ms = sample.time_ms;
                                last_x_next          = smooth.x;
                                last_y_next          = smooth.y;
                                last_time_next       = sample.time_ms;
                            end
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_reg     <= 1'b0;
            awaiting_reg    <= 1'b0;
            clear_run_reg   <= '0;
            cand_run_reg    <= '0;
            release_run_reg <= '0;
            error_run_reg   <= '0;
            cand_reg        <= '0;
            stable_reg      <= '0;
            last_x_reg      <= '0;
            last_y_reg      <= '0;
            last_time_reg   <= '0;
        end
        else if (step)
        begin
            pressed_reg     <= pressed_next;
            awaiting_reg    <= awaiting_next;
            clear_run_reg   <= clear_run_next;
            cand_run_reg    <= cand_run_next;
            release_run_reg <= release_run_next;
            error_run_reg   <= error_run_next;
            cand_reg        <= cand_next;
            stable_reg      <= stable_next;
            last_x_reg      <= last_x_next;
            last_y_reg      <= last_y_next;
            last_time_reg   <= last_time_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/touch_point_press_move_release_qualifier.sv
// Touch point press / move / release qualifier.
//
// Input channel (in_valid, in_ready, in_data): one controller sample per word,
// either a bus error, a status report with the first raw point, or a
// recovery-done mark. Output channel (out_valid, out_ready, out_data): exactly
// one result word per input word, in order, with the event kind, the event
// point, the sample class and the recover request.
// Configuration: cfg_write writes cfg_data into register cfg_index at the
// clock edge; write only while no word is in flight.
// An accepted word is held in the input register, its result in the result
// register on out_data. Throughput: one word per cycle unless out_ready stalls;
// the state update and the result are one pass of logic between the two.
// Reset: all qualifier state clears, registers return to their defaults and
// both channels come up empty.
// Stall: while out_ready is low the result holds; the input register still
// takes one more word, then in_ready drops until the result is taken.
`default_nettype none

module touch_point_press_move_release_qualifier
    import tpq_pkg::*;
(
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    output logic                   in_ready,
    input  wire in_word_t          in_data,
    output logic                   out_valid,
    input  wire                    out_ready,
    output out_word_t              out_data,
    input  wire                    cfg_write,
    input  wire [2:0]              cfg_index,
    input  wire [CFG_DATA_W-1:0]   cfg_data
);

    logic      in_valid_reg, in_valid_next;
    in_word_t  in_data_reg;
    logic      out_valid_reg, out_valid_next;
    out_word_t out_data_reg;
    cfg_t      cfg_reg;
    logic      advance;
    logic      step;
    map_t      map;
    out_word_t result;

    always_comb
    begin
        advance        = !out_valid_reg || out_ready;
        step           = in_valid_reg && advance;
        in_ready       = !in_valid_reg || advance;
        in_valid_next  = in_ready ? in_valid : in_valid_reg;
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_data_reg <= in_data;
        end
        if (step)
        begin
            out_data_reg <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.raw_width        <= 12'd480;
            cfg_reg.raw_height       <= 12'd800;
            cfg_reg.cand_radius_sq   <= 20'd900;
            cfg_reg.move_radius_sq   <= 20'd16;
            cfg_reg.move_interval_ms <= 16'd60;
            cfg_reg.press_samples    <= 4'd2;
            cfg_reg.release_samples  <= 4'd2;
            cfg_reg.error_threshold  <= 8'd3;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_RAW_WIDTH:       cfg_reg.raw_width        <= cfg_data[11:0];
                REG_RAW_HEIGHT:      cfg_reg.raw_height       <= cfg_data[11:0];
                REG_CAND_RADIUS_SQ:  cfg_reg.cand_radius_sq   <= cfg_data[19:0];
                REG_MOVE_RADIUS_SQ:  cfg_reg.move_radius_sq   <= cfg_data[19:0];
                REG_MOVE_INTERVAL:   cfg_reg.move_interval_ms <= cfg_data[15:0];
                REG_PRESS_SAMPLES:   cfg_reg.press_samples    <= cfg_data[3:0];
                REG_RELEASE_SAMPLES: cfg_reg.release_samples  <= cfg_data[3:0];
                REG_ERROR_THRESHOLD: cfg_reg.error_threshold  <= cfg_data[7:0];
            endcase
        end
    end

    tpq_map u_map (
        .sample (in_data_reg),
        .cfg    (cfg_reg),
        .map    (map)
    );

    tpq_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .sample (in_data_reg),
        .map    (map),
        .cfg    (cfg_reg),
        .result (result)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// File: rtl/tpq_checker.sv
`default_nettype none

module tpq_checker
    import tpq_pkg::*;
(
    input wire            clk,
    input wire            rst_n,
    input wire            out_valid,
    input wire            out_ready,
    input wire out_word_t out_data
);

    // recover request only on a bus error word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.recover_request |-> out_data.sample_class == CLS_BUS_ERROR)
        else $error("recover request on a non bus error word");

    // no event carries no point
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.event_kind == EV_NONE |->
            out_data.point_x == '0 && out_data.point_y == '0
            && out_data.point_raw_x == '0 && out_data.point_raw_y == '0
            && out_data.touch_count == '0 && out_data.event_time_ms == '0)
        else $error("point fields set without an event");

    // press and move come from touch samples with a point count, inside the display
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.event_kind == EV_PRESSED || out_data.event_kind == EV_MOVED)
            |-> out_data.sample_class == CLS_TOUCH && out_data.touch_count != '0
            && out_data.point_y <= DISP_Y_MAX && out_data.point_x <= DISP_X_MAX)
        else $error("press or move on a bad sample");

    // release comes from an idle sample
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.event_kind == EV_RELEASED
            |-> out_data.sample_class == CLS_IDLE && out_data.touch_count == '0)
        else $error("release on a non idle sample");

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result word changed");

endmodule

bind touch_point_press_move_release_qualifier tpq_checker u_tpq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
    import tpq_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 60;
    localparam int PHASE_ITEMS  = 180;

    typedef struct {
        in_word_t  w;
        bit        typed;
        out_word_t want;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    in_word_t              in_data;
    logic                  out_valid;
    logic                  out_ready;
    out_word_t             out_data;
    logic                  cfg_write;
    cfg_index_t            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // qualifier shadow state
    cfg_t        cfg_q;
    logic        pressed_q;
    logic        awaiting_q;
    logic [3:0]  clear_run_q;
    logic [3:0]  cand_run_q;
    logic [3:0]  rel_run_q;
    logic [7:0]  err_run_q;
    point_t      cand_pt;
    point_t      stable_pt;
    logic [9:0]  last_x;
    logic [8:0]  last_y;
    logic [31:0] last_time;

    out_word_t   expected_results[$];
    stim_row_t   directed_rows[$];
    int          mismatches = 0;
    int          results_seen = 0;
    int          samples_sent = 0;
    int          settings_used = 0;
    int          n_events[4] = '{0, 0, 0, 0};
    int          n_recover = 0;
    int          tx_idle_pct;
    int          rx_idle_pct;
    int          holds_asked = 0;
    int          holds_done = 0;
    logic [31:0] cur_time;

    touch_point_press_move_release_qualifier uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [3:0] bump4(logic [3:0] v);
        return (v == 4'd15) ? v : v + 4'd1;
    endfunction

    function automatic int dist2(int ax, int ay, int bx, int by);
        return (ax - bx) * (ax - bx) + (ay - by) * (ay - by);
    endfunction

    function automatic int smooth(int p, int s);
        return (p * 3 + s + 2) / 4;
    endfunction

    function automatic out_word_t no_event(sample_class_t c, logic rr);
        out_word_t r;
        r = '0;
        r.sample_class = c;
        r.recover_request = rr;
        return r;
    endfunction

    function automatic out_word_t emit_event(out_word_t r, event_kind_t k, point_t p,
                                             logic [2:0] c, logic [31:0] t);
        r.event_kind    = k;
        r.point_x       = p.x;
        r.point_y       = p.y;
        r.point_raw_x   = p.rx;
        r.point_raw_y   = p.ry;
        r.touch_count   = c;
        r.event_time_ms = t;
        last_x    = p.x;
        last_y    = p.y;
        last_time = t;
        return r;
    endfunction

    function automatic out_word_t qualify_sample(in_word_t w);
        out_word_t  r;
        point_t     s;
        logic [3:0] cnt;
        int         sy;
        r = no_event(CLS_INVALID, 1'b0);
        cnt = w.status_byte[3:0];
        if (w.command == CMD_RESERVED)
            return r;
        if (w.command == CMD_BUS_ERROR)
        begin
            if (err_run_q != 8'd255)
                err_run_q = err_run_q + 8'd1;
            return no_event(CLS_BUS_ERROR, err_run_q >= cfg_q.error_threshold);
        end
        if (w.command == CMD_RECOVERED)
        begin
            err_run_q   = '0;
            cand_run_q  = '0;
            rel_run_q   = '0;
            pressed_q   = 1'b0;
            awaiting_q  = 1'b1;
            clear_run_q = '0;
            return no_event(CLS_RECOVERED, 1'b0);
        end
        err_run_q = '0;
        if (cnt == 4'd0 || cnt > COUNT_MAX)
        begin
            r.sample_class = CLS_IDLE;
            if (awaiting_q)
            begin
                clear_run_q = bump4(clear_run_q);
                if (clear_run_q >= cfg_q.release_samples)
                begin
                    awaiting_q  = 1'b0;
                    clear_run_q = '0;
                end
                return r;
            end
            cand_run_q = '0;
            if (!pressed_q)
                return r;
            rel_run_q = bump4(rel_run_q);
            if (rel_run_q < cfg_q.release_samples)
                return r;
            pressed_q = 1'b0;
            rel_run_q = '0;
            return emit_event(r, EV_RELEASED, stable_pt, 3'd0, w.time_ms);
        end
        if (w.raw_x >= cfg_q.raw_width || w.raw_y >= cfg_q.raw_height)
            return r;

        // mirror x, swap onto landscape, clamp
        r.sample_class = CLS_TOUCH;
        s.rx = w.raw_x;
        s.ry = w.raw_y;
        s.x  = (w.raw_y < 12'(DISP_X_MAX)) ? w.raw_y[9:0] : DISP_X_MAX;
        sy   = int'(cfg_q.raw_width) - 1 - int'(w.raw_x);
        s.y  = (sy > int'(DISP_Y_MAX)) ? DISP_Y_MAX : sy[8:0];
        if (awaiting_q)
        begin
            clear_run_q = '0;
            return r;
        end
        rel_run_q = '0;
        if (!pressed_q)
        begin
            if (cand_run_q == 4'd0 ||
                dist2(cand_pt.x, cand_pt.y, s.x, s.y) > int'(cfg_q.cand_radius_sq))
            begin
                cand_pt    = s;
                cand_run_q = 4'd1;
                return r;
            end
            cand_pt.x  = 10'((int'(cand_pt.x) + int'(s.x)) / 2);
            cand_pt.y  = 9'((int'(cand_pt.y) + int'(s.y)) / 2);
            cand_pt.rx = 12'((int'(cand_pt.rx) + int'(s.rx)) / 2);
            cand_pt.ry = 12'((int'(cand_pt.ry) + int'(s.ry)) / 2);
            cand_run_q = bump4(cand_run_q);
            if (cand_run_q < cfg_q.press_samples)
                return r;
            pressed_q  = 1'b1;
            cand_run_q = '0;
            stable_pt  = cand_pt;
            return emit_event(r, EV_PRESSED, stable_pt, cnt[2:0], w.time_ms);
        end
        stable_pt.x  = 10'(smooth(stable_pt.x, s.x));
        stable_pt.y  = 9'(smooth(stable_pt.y, s.y));
        stable_pt.rx = 12'(smooth(stable_pt.rx, s.rx));
        stable_pt.ry = 12'(smooth(stable_pt.ry, s.ry));
        if (dist2(stable_pt.x, stable_pt.y, last_x, last_y) < int'(cfg_q.move_radius_sq) ||
            (w.time_ms - last_time) < 32'(cfg_q.move_interval_ms))
            return r;
        return emit_event(r, EV_MOVED, stable_pt, cnt[2:0], w.time_ms);
    endfunction

    function automatic in_word_t sample(command_t c, logic [7:0] st, logic [11:0] x,
                                        logic [11:0] y, logic [31:0] t);
        in_word_t w;
        w.command     = c;
        w.status_byte = st;
        w.raw_x       = x;
        w.raw_y       = y;
        w.time_ms     = t;
        return w;
    endfunction

    function automatic logic [31:0] next_time();
        if ($urandom_range(0, 63) == 0)
            cur_time += $urandom;
        else
            cur_time += $urandom_range(0, 40);
        return cur_time;
    endfunction

    task automatic note_field(string name, longint unsigned want, longint unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    task automatic check_result(out_word_t want, out_word_t got);
        note_field("event_kind", want.event_kind, got.event_kind);
        note_field("point_x", want.point_x, got.point_x);
        note_field("point_y", want.point_y, got.point_y);
        note_field("point_raw_x", want.point_raw_x, got.point_raw_x);
        note_field("point_raw_y", want.point_raw_y, got.point_raw_y);
        note_field("touch_count", want.touch_count, got.touch_count);
        note_field("event_time_ms", want.event_time_ms, got.event_time_ms);
        note_field("sample_class", want.sample_class, got.sample_class);
        note_field("recover_request", want.recover_request, got.recover_request);
    endtask

    task automatic send_sample(in_word_t w, bit typed, out_word_t want);
        out_word_t predicted;
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = qualify_sample(w);
        expected_results.push_back(typed ? want : predicted);
        samples_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(cfg_t c);
        logic [CFG_DATA_W-1:0] d;
        for (int i = 0; i < 8; i++)
        begin
            case (cfg_index_t'(i))
                REG_RAW_WIDTH:       d = 20'(c.raw_width);
                REG_RAW_HEIGHT:      d = 20'(c.raw_height);
                REG_CAND_RADIUS_SQ:  d = c.cand_radius_sq;
                REG_MOVE_RADIUS_SQ:  d = c.move_radius_sq;
                REG_MOVE_INTERVAL:   d = 20'(c.move_interval_ms);
                REG_PRESS_SAMPLES:   d = 20'(c.press_samples);
                REG_RELEASE_SAMPLES: d = 20'(c.release_samples);
                default:             d = 20'(c.error_threshold);
            endcase
            cfg_write <= 1'b1;
            cfg_index <= cfg_index_t'(i);
            cfg_data  <= d;
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        @(posedge clk);
        cfg_q = c;
        settings_used++;
    endtask

    task automatic send_noise();
        int pick;
        int burst;
        pick = $urandom_range(0, 99);
        if (pick < 35)
        begin
            burst = $urandom_range(1, (cfg_q.error_threshold < 8'd8) ?
                                      int'(cfg_q.error_threshold) + 1 : 8);
            repeat (burst)
                send_sample(sample(CMD_BUS_ERROR, 8'($urandom), 12'($urandom),
                                   12'($urandom), next_time()), 1'b0, '0);
        end
        else if (pick < 55)
            send_sample(sample(CMD_RECOVERED, 8'($urandom), 12'($urandom),
                               12'($urandom), next_time()), 1'b0, '0);
        else if (pick < 75)
            send_sample(sample(CMD_REPORT, {4'($urandom), 4'($urandom_range(1, 5))},
                               12'($urandom_range(int'(cfg_q.raw_width), 4095)),
                               12'($urandom), next_time()), 1'b0, '0);
        else if (pick < 85)
            send_sample(sample(CMD_RESERVED, 8'($urandom), 12'($urandom),
                               12'($urandom), next_time()), 1'b0, '0);
        else
            send_sample(sample(command_t'($urandom_range(0, 3)), 8'($urandom),
                               12'($urandom), 12'($urandom), $urandom), 1'b0, '0);
    endtask

    // gestures: a run of nearby touches, then idle reports, with noise mixed in
    task automatic run_gestures(int target);
        int fx;
        int fy;
        int touches;
        int idles;
        int hold_at;
        bit held;
        held    = 1'b0;
        hold_at = samples_sent + (target - samples_sent) / 2;
        while (samples_sent < target)
        begin
            fx = $urandom_range(0, int'(cfg_q.raw_width) - 1);
            fy = $urandom_range(0, int'(cfg_q.raw_height) - 1);
            touches = $urandom_range(1, 24);
            repeat (touches)
            begin
                if (!held && samples_sent >= hold_at)
                begin
                    holds_asked++;
                    held = 1'b1;
                end
                if ($urandom_range(0, 9) == 0)
                    send_noise();
                if ($urandom_range(0, 7) == 0)
                begin
                    fx += int'($urandom_range(0, 120)) - 60;
                    fy += int'($urandom_range(0, 120)) - 60;
                end
                else
                begin
                    fx += int'($urandom_range(0, 8)) - 4;
                    fy += int'($urandom_range(0, 8)) - 4;
                end
                if (fx < 0)
                    fx = 0;
                if (fx > int'(cfg_q.raw_width) - 1)
                    fx = int'(cfg_q.raw_width) - 1;
                if (fy < 0)
                    fy = 0;
                if (fy > int'(cfg_q.raw_height) - 1)
                    fy = int'(cfg_q.raw_height) - 1;
                send_sample(sample(CMD_REPORT, {4'($urandom), 4'($urandom_range(1, 5))},
                                   12'(fx), 12'(fy), next_time()), 1'b0, '0);
            end
            idles = $urandom_range(0, int'(cfg_q.release_samples) + 1);
            repeat (idles)
                send_sample(sample(CMD_REPORT,
                                   {4'($urandom), $urandom_range(0, 1) ? 4'd0 :
                                                  4'($urandom_range(6, 15))},
                                   12'($urandom), 12'($urandom), next_time()), 1'b0, '0);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            n_events[out_data.event_kind]++;
            if (out_data.recover_request)
                n_recover++;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: result with nothing expected, got %p", $time, out_data);
            end
            else
                check_result(expected_results.pop_front(), out_data);
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_asked != holds_done)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_done++;
                out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
            else
                out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    initial
    begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles, %0d results pending", $time, cycle_count,
                 expected_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        cfg_t setting;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        cfg_write    = 1'b0;
        cfg_index    = REG_RAW_WIDTH;
        cfg_data     = '0;
        tx_idle_pct  = 10;
        rx_idle_pct  = 48;
        cur_time     = '0;
        cfg_q        = '{12'd480, 12'd800, 20'd900, 20'd16, 16'd60, 4'd2, 4'd2, 8'd3};
        pressed_q    = 1'b0;
        awaiting_q   = 1'b0;
        clear_run_q  = '0;
        cand_run_q   = '0;
        rel_run_q    = '0;
        err_run_q    = '0;
        cand_pt      = '0;
        stable_pt    = '0;
        last_x       = '0;
        last_y       = '0;
        last_time    = '0;

        // defaults after reset; no-event rows typed in
        directed_rows.push_back('{sample(CMD_BUS_ERROR, 8'h00, 12'h000, 12'h000, 32'h0),
                                  1'b1, no_event(CLS_BUS_ERROR, 1'b0)});
        directed_rows.push_back('{sample(CMD_BUS_ERROR, 8'hFF, 12'hFFF, 12'hFFF,
                                         32'hFFFF_FFFF), 1'b1, no_event(CLS_BUS_ERROR, 1'b0)});
        directed_rows.push_back('{sample(CMD_BUS_ERROR, 8'h00, 12'h000, 12'h000, 32'd5),
                                  1'b1, no_event(CLS_BUS_ERROR, 1'b1)});
        directed_rows.push_back('{sample(CMD_RESERVED, 8'hFF, 12'hFFF, 12'hFFF,
                                         32'hFFFF_FFFF), 1'b1, no_event(CLS_INVALID, 1'b0)});
        directed_rows.push_back('{sample(CMD_BUS_ERROR, 8'h00, 12'h000, 12'h000, 32'd8),
                                  1'b1, no_event(CLS_BUS_ERROR, 1'b1)});
        directed_rows.push_back('{sample(CMD_REPORT, 8'hF0, 12'hFFF, 12'hFFF, 32'd10),
                                  1'b1, no_event(CLS_IDLE, 1'b0)});
        directed_rows.push_back('{sample(CMD_REPORT, 8'h06, 12'h000, 12'h000, 32'd20),
                                  1'b1, no_event(CLS_IDLE, 1'b0)});
        directed_rows.push_back('{sample(CMD_REPORT, 8'h0F, 12'h000, 12'h000, 32'd30),
                                  1'b1, no_event(CLS_IDLE, 1'b0)});
        directed_rows.push_back('{sample(CMD_REPORT, 8'h01, 12'd480, 12'd0, 32'd40),
                                  1'b1, no_event(CLS_INVALID, 1'b0)});
        directed_rows.push_back('{sample(CMD_REPORT, 8'h01, 12'd0, 12'd800, 32'd50),
                                  1'b1, no_event(CLS_INVALID, 1'b0)});
        directed_rows.push_back('{sample(CMD_REPORT, 8'h05, 12'hFFF, 12'hFFF, 32'd60),
                                  1'b1, no_event(CLS_INVALID, 1'b0)});
        // press, moves, interval hold, release
        directed_rows.push_back('{sample(CMD_REPORT, 8'h01, 12'd0, 12'd0, 32'd100), 1'b0, '0});
        directed_rows.push_back('{sample(CMD_REPORT, 8'h05, 12'd2, 12'd2, 32'd110), 1'b0, '0});
        directed_rows.push_back('{sample(CMD_REPORT, 8'h02, 12'd479, 12'd799, 32'd200),
                                  1'b0, '0});
        directed_rows.push_back('{sample(CMD_REPORT, 8'h02, 12'd479, 12'd799, 32'd201),
                                  1'b0, '0});
        directed_rows.push_back('{sample(CMD_REPORT, 8'hA3, 12'd100, 12'd400, 32'd300),
                                  1'b0, '0});
        directed_rows.push_back('{sample(CMD_REPORT, 8'h00, 12'd0, 12'd0, 32'd320), 1'b0, '0});
        directed_rows.push_back('{sample(CMD_REPORT, 8'h00, 12'd0, 12'd0, 32'd340), 1'b0, '0});
        // recovery, then re-arm on idle reports
        directed_rows.push_back('{sample(CMD_RECOVERED, 8'h00, 12'd0, 12'd0, 32'd400),
                                  1'b1, no_event(CLS_RECOVERED, 1'b0)});
        directed_rows.push_back('{sample(CMD_REPORT, 8'h01, 12'd10, 12'd10, 32'd410),
                                  1'b0, '0});
        directed_rows.push_back('{sample(CMD_REPORT, 8'h00, 12'd0, 12'd0, 32'd420),
                                  1'b1, no_event(CLS_IDLE, 1'b0)});
        directed_rows.push_back('{sample(CMD_REPORT, 8'h80, 12'd0, 12'd0, 32'd430),
                                  1'b1, no_event(CLS_IDLE, 1'b0)});
        // timestamp wrap across press and move
        directed_rows.push_back('{sample(CMD_REPORT, 8'h04, 12'd200, 12'd300, 32'hFFFF_FFF0),
                                  1'b0, '0});
        directed_rows.push_back('{sample(CMD_REPORT, 8'h04, 12'd200, 12'd300, 32'h0000_0010),
                                  1'b0, '0});
        directed_rows.push_back('{sample(CMD_REPORT, 8'h04, 12'd0, 12'd0, 32'h0000_0100),
                                  1'b0, '0});

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_sample(directed_rows[i].w, directed_rows[i].typed, directed_rows[i].want);
        wait_drained();

        cur_time = $urandom;
        for (int p = 0; p < 6; p++)
        begin
            tx_idle_pct <= (p < 2) ? 10 : (p < 4) ? 48 : 0;
            rx_idle_pct <= (p < 2) ? 48 : (p < 4) ? 10 : 0;
            case (p)
                0: setting = '{12'd480, 12'd800, 20'd900, 20'd16, 16'd60, 4'd2, 4'd2, 8'd3};
                1: setting = '{12'd4095, 12'd4095, 20'hFFFFF, 20'd0, 16'd0, 4'd1, 4'd1, 8'd1};
                2: setting = '{12'd1, 12'd1, 20'd0, 20'hFFFFF, 16'hFFFF, 4'd15, 4'd15,
                               8'd255};
                4:
                begin
                    setting.raw_width        = 12'($urandom_range(1, 4095));
                    setting.raw_height       = 12'($urandom_range(1, 4095));
                    setting.cand_radius_sq   = 20'($urandom);
                    setting.move_radius_sq   = 20'($urandom_range(0, 2000));
                    setting.move_interval_ms = 16'($urandom_range(0, 300));
                    setting.press_samples    = 4'($urandom_range(1, 15));
                    setting.release_samples  = 4'($urandom_range(1, 15));
                    setting.error_threshold  = 8'($urandom_range(1, 255));
                end
                default:
                begin
                    setting.raw_width        = 12'($urandom_range(200, 1200));
                    setting.raw_height       = 12'($urandom_range(200, 1200));
                    setting.cand_radius_sq   = 20'($urandom_range(0, 5000));
                    setting.move_radius_sq   = 20'($urandom_range(0, 400));
                    setting.move_interval_ms = 16'($urandom_range(0, 200));
                    setting.press_samples    = 4'($urandom_range(1, 4));
                    setting.release_samples  = 4'($urandom_range(1, 4));
                    setting.error_threshold  = 8'($urandom_range(1, 6));
                end
            endcase
            set_config(setting);
            // drive the error counter into saturation
            if (cfg_q.error_threshold == 8'd255)
                repeat (260)
                    send_sample(sample(CMD_BUS_ERROR, 8'($urandom), 12'($urandom),
                                       12'($urandom), next_time()), 1'b0, '0);
            run_gestures(samples_sent + PHASE_ITEMS);
            wait_drained();
        end

        $display("Ran %0d samples (%0d directed) through %0d register settings, %0d results.",
                 samples_sent, directed_rows.size(), settings_used, results_seen);
        $display("Events seen: %0d pressed, %0d moved, %0d released; %0d recover requests.",
                 n_events[EV_PRESSED], n_events[EV_MOVED], n_events[EV_RELEASED], n_recover);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
        begin
            $display("%0d mismatches, %0d results never arrived", mismatches,
                     expected_results.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/tpq_pkg.sv
rtl/tpq_map.sv
rtl/tpq_core.sv
rtl/touch_point_press_move_release_qualifier.sv
rtl/tpq_checker.sv
tb/sv/tb.sv
